// ===== rtl/core/mccp_pkg.sv =====
// ----------------------------------------------------------------------------
// mccp_pkg: marching-cubes cell polygonizer package
// Widths, register indexes and the triangle table.
// ----------------------------------------------------------------------------
package mccp_pkg;

    localparam int SCALAR_WIDTH = 16;
    localparam int COORD_WIDTH  = 24;
    localparam int STEP_WIDTH   = COORD_WIDTH - 1;
    localparam int CFG_IDX_WIDTH = 2;
    // difference of scalars needs one extra bit
    localparam int DIFF_WIDTH   = SCALAR_WIDTH + 1;
    // corner-to-corner span magnitude, at most one step
    localparam int MAG_WIDTH    = STEP_WIDTH;
    localparam int PROD_WIDTH   = MAG_WIDTH + DIFF_WIDTH;
    localparam int QUOT_WIDTH   = MAG_WIDTH + 1;
    localparam int DIV_CNT_WIDTH = $clog2(PROD_WIDTH + 1);
    // corner coordinate before saturation
    localparam int WIDE_WIDTH   = COORD_WIDTH + 1;

    typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_ISO    = 2'd0;
    localparam cfg_idx_t REG_STEP_X = 2'd1;
    localparam cfg_idx_t REG_STEP_Y = 2'd2;
    localparam cfg_idx_t REG_STEP_Z = 2'd3;

    localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(4096);

    typedef logic [3:0] edge_t;

    // row: edges holds 15 nibbles (entry 0 in bits 3:0); count is the 4-bit number of entries used
    typedef struct packed {
        logic [59:0] edges;
        logic [3:0]  count;
    } tri_row_t;

    function automatic tri_row_t mk_row(input string s);
        tri_row_t r;
        logic [7:0] ch;
        r = '0;
        r.count = 4'(s.len());
        for (int i = 0; i < s.len(); i++) begin
            ch = s[i];
            if (ch >= 8'h61)
                r.edges[i*4 +: 4] = 4'(ch - 8'h61 + 8'd10);
            else
                r.edges[i*4 +: 4] = 4'(ch - 8'h30);
        end
        return r;
    endfunction

    function automatic tri_row_t tri_row(input logic [7:0] idx);
        string s;
        unique case (idx)
8'd0: s=""; 8'd1: s="083"; 8'd2: s="019"; 8'd3: s="183981"; 8'd4: s="12a";
8'd5: s="08312a"; 8'd6: s="92a029"; 8'd7: s="2832a8a98"; 8'd8: s="3b2";
8'd9: s="0b28b0"; 8'd10: s="19023b"; 8'd11: s="1b219b98b"; 8'd12: s="3a1ba3";
8'd13: s="0a108a8ba"; 8'd14: s="3903b9ba9"; 8'd15: s="98aa8b"; 8'd16: s="478";
8'd17: s="430734"; 8'd18: s="019847"; 8'd19: s="419471731"; 8'd20: s="12a847";
8'd21: s="34730412a"; 8'd22: s="92a902847"; 8'd23: s="2a9297273794";
8'd24: s="8473b2"; 8'd25: s="b47b24204"; 8'd26: s="90184723b";
8'd27: s="47b94b9b2921"; 8'd28: s="3a13ba784"; 8'd29: s="1ba14b1047b4";
8'd30: s="47890b9bab03"; 8'd31: s="47b4b99ba"; 8'd32: s="954"; 8'd33: s="954083";
8'd34: s="054150"; 8'd35: s="854835315"; 8'd36: s="12a954"; 8'd37: s="30812a495";
8'd38: s="52a542402"; 8'd39: s="2a5325354348"; 8'd40: s="9543b2";
8'd41: s="0b208b495"; 8'd42: s="05401523b"; 8'd43: s="21525828b485";
8'd44: s="a3ba13954"; 8'd45: s="4950818a18ba"; 8'd46: s="54050b5bab03";
8'd47: s="54858aa8b"; 8'd48: s="978579"; 8'd49: s="930953573";
8'd50: s="078017157"; 8'd51: s="153357"; 8'd52: s="978957a12";
8'd53: s="a12950530573"; 8'd54: s="802825857a52"; 8'd55: s="2a5253357";
8'd56: s="7957893b2"; 8'd57: s="95797292027b"; 8'd58: s="23b018178157";
8'd59: s="b21b17715"; 8'd60: s="958857a13a3b"; 8'd61: s="5705097b010aba0";
8'd62: s="ba0b03a50807570"; 8'd63: s="ba57b5"; 8'd64: s="a65"; 8'd65: s="0835a6";
8'd66: s="9015a6"; 8'd67: s="1831985a6"; 8'd68: s="165261"; 8'd69: s="165126308";
8'd70: s="965906026"; 8'd71: s="598582526328"; 8'd72: s="23ba65";
8'd73: s="b08b20a65"; 8'd74: s="01923b5a6"; 8'd75: s="5a61929b298b";
8'd76: s="63b653513"; 8'd77: s="08b0b50515b6"; 8'd78: s="3b6036065059";
8'd79: s="65969bb98"; 8'd80: s="5a6478"; 8'd81: s="43047365a";
8'd82: s="1905a6847"; 8'd83: s="a65197173794"; 8'd84: s="612651478";
8'd85: s="125526304347"; 8'd86: s="847905065026"; 8'd87: s="739794329596269";
8'd88: s="3b2784a65"; 8'd89: s="5a647242027b"; 8'd90: s="01947823b5a6";
8'd91: s="9219b294b7b45a6"; 8'd92: s="8473b53515b6"; 8'd93: s="51b5b610b7b404b";
8'd94: s="059065036b63847"; 8'd95: s="65969b4797b9"; 8'd96: s="a4964a";
8'd97: s="4a649a083"; 8'd98: s="a01a06640"; 8'd99: s="83181686461a";
8'd100: s="149124264"; 8'd101: s="308129249264"; 8'd102: s="024426";
8'd103: s="832824426"; 8'd104: s="a49a64b23"; 8'd105: s="08228b49a4a6";
8'd106: s="3b201606461a"; 8'd107: s="64161a48121b8b1"; 8'd108: s="964936913b63";
8'd109: s="8b1810b61914641"; 8'd110: s="3b6360064"; 8'd111: s="648b68";
8'd112: s="7a678a89a"; 8'd113: s="0730a709a67a"; 8'd114: s="a671a7178180";
8'd115: s="a67a71173"; 8'd116: s="126168189867"; 8'd117: s="269291679093739";
8'd118: s="780706602"; 8'd119: s="732672"; 8'd120: s="23ba68a89867";
8'd121: s="20727b09767a9a7"; 8'd122: s="1801781a767a23b"; 8'd123: s="b21b17a61671";
8'd124: s="896867916b63136"; 8'd125: s="091b67"; 8'd126: s="7807063b0b60";
8'd127: s="7b6"; 8'd128: s="76b"; 8'd129: s="308b76"; 8'd130: s="019b76";
8'd131: s="819831b76"; 8'd132: s="a126b7"; 8'd133: s="12a3086b7";
8'd134: s="2902a96b7"; 8'd135: s="6b72a3a83a98"; 8'd136: s="723627";
8'd137: s="708760620"; 8'd138: s="276237019"; 8'd139: s="162186198876";
8'd140: s="a76a17137"; 8'd141: s="a7617a187108"; 8'd142: s="03707a0a96a7";
8'd143: s="76a7a88a9"; 8'd144: s="684b86"; 8'd145: s="36b306046";
8'd146: s="86b846901"; 8'd147: s="946963931b36"; 8'd148: s="6846b82a1";
8'd149: s="12a30b06b046"; 8'd150: s="4b846b0292a9"; 8'd151: s="a93a32943b36463";
8'd152: s="823842462"; 8'd153: s="042462"; 8'd154: s="190234246438";
8'd155: s="194142246"; 8'd156: s="8138618466a1"; 8'd157: s="a10a06604";
8'd158: s="4634386a3039a93"; 8'd159: s="a946a4"; 8'd160: s="49576b";
8'd161: s="083495b76"; 8'd162: s="50154076b"; 8'd163: s="b76834354315";
8'd164: s="954a1276b"; 8'd165: s="6b712a083495"; 8'd166: s="76b54a42a402";
8'd167: s="348354325a52b76"; 8'd168: s="723762549"; 8'd169: s="954086062687";
8'd170: s="362376150540"; 8'd171: s="628687218485158"; 8'd172: s="954a16176137";
8'd173: s="16a176107870954"; 8'd174: s="40a4a503a6a737a"; 8'd175: s="76a7a854a48a";
8'd176: s="6956b9b89"; 8'd177: s="36b063056095"; 8'd178: s="0b805b01556b";
8'd179: s="6b3635531"; 8'd180: s="12a95b9b8b56"; 8'd181: s="0b306b09656912a";
8'd182: s="b85b56805a52025"; 8'd183: s="6b36352a3a53"; 8'd184: s="589528562382";
8'd185: s="956960062"; 8'd186: s="158180568382628"; 8'd187: s="156216";
8'd188: s="13616a386569896"; 8'd189: s="a10a06950560"; 8'd190: s="03856a";
8'd191: s="a56"; 8'd192: s="b5a75b"; 8'd193: s="b5ab75830"; 8'd194: s="5b75ab190";
8'd195: s="a75ab7981831"; 8'd196: s="b12b17751"; 8'd197: s="08312717572b";
8'd198: s="9759279022b7"; 8'd199: s="75272b592328982"; 8'd200: s="25a235375";
8'd201: s="820852875a25"; 8'd202: s="9015a35373a2"; 8'd203: s="982921872a25752";
8'd204: s="135375"; 8'd205: s="087071175"; 8'd206: s="903935537";
8'd207: s="987597"; 8'd208: s="5845a8ab8"; 8'd209: s="5045b05abb30";
8'd210: s="01984a8aba45"; 8'd211: s="ab4a45b34941314"; 8'd212: s="2512852b8458";
8'd213: s="04b0b345b2b151b"; 8'd214: s="0250592b5458b85"; 8'd215: s="9452b3";
8'd216: s="25a352345384"; 8'd217: s="5a2524420"; 8'd218: s="3a235a385458019";
8'd219: s="5a2524192942"; 8'd220: s="845853351"; 8'd221: s="045105";
8'd222: s="845853905035"; 8'd223: s="945"; 8'd224: s="4b749b9ab";
8'd225: s="0834979b79ab"; 8'd226: s="1ab1b414074b"; 8'd227: s="3143481a474bab4";
8'd228: s="4b79b492b912"; 8'd229: s="9749b791b2b1083"; 8'd230: s="b74b42240";
8'd231: s="b74b42834324"; 8'd232: s="29a279237749"; 8'd233: s="9a7974a27870207";
8'd234: s="37a3a274a1a040a"; 8'd235: s="1a2874"; 8'd236: s="491417713";
8'd237: s="491417081871"; 8'd238: s="403743"; 8'd239: s="487"; 8'd240: s="9a8ab8";
8'd241: s="30939bb9a"; 8'd242: s="01a0a88ab"; 8'd243: s="31ab3a";
8'd244: s="12b1b99b8"; 8'd245: s="30939b1292b9"; 8'd246: s="02b80b";
8'd247: s="32b"; 8'd248: s="23828aa89"; 8'd249: s="9a2092"; 8'd250: s="23828a0181a8";
8'd251: s="1a2"; 8'd252: s="138918"; 8'd253: s="091"; 8'd254: s="038";
default: s="";
        endcase
        return mk_row(s);
    endfunction

    function automatic logic [2:0] edge_a(input edge_t e);
        logic [2:0] r;
        case (e)
            4'd8:    r = 3'd0;
            4'd9:    r = 3'd1;
            4'd10:   r = 3'd2;
            4'd11:   r = 3'd3;
            default: r = e[2:0];
        endcase
        return r;
    endfunction

    function automatic logic [2:0] edge_b(input edge_t e);
        logic [2:0] r;
        case (e)
            4'd0:    r = 3'd1;
            4'd1:    r = 3'd2;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd0;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd6;
            4'd6:    r = 3'd7;
            4'd7:    r = 3'd4;
            default: r = {1'b1, e[1:0]};
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/marching_cubes_cell_polygonizer.sv =====
// ----------------------------------------------------------------------------
// marching_cubes_cell_polygonizer
// Classifies one voxel cell and emits its triangle vertices, interpolated
// along the cut edges by one shared restoring divider.
// ----------------------------------------------------------------------------
// channel | signals                                    | direction
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | in
// cell    | in_valid, in_stall, corner_value_*, origin_*| in
// vertex  | out_valid, out_stall, vertex_*, cut_edge,   | out
//         | last_vertex                                |
// A cell is accepted and classified; then each vertex takes one edge fetch, three
// passes of the shared divider (setup, one quotient bit a cycle, finish) and
// one output beat. An empty cell goes back to idle after classification.
// rst_n clears control and iso and loads STEP_RESET into the step registers.
// A stalled output beat holds the sequencer; no cell is accepted until the
// last vertex beat of the previous one has gone.
// ----------------------------------------------------------------------------
module marching_cubes_cell_polygonizer
    import mccp_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]       cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SCALAR_WIDTH-1:0] corner_value_0,
    input  logic signed [SCALAR_WIDTH-1:0] corner_value_1,
    input  logic signed [SCALAR_WIDTH-1:0] corner_value_2,
    input  logic signed [SCALAR_WIDTH-1:0] corner_value_3,
    input  logic signed [SCALAR_WIDTH-1:0] corner_value_4,
    input  logic signed [SCALAR_WIDTH-1:0] corner_value_5,
    input  logic signed [SCALAR_WIDTH-1:0] corner_value_6,
    input  logic signed [SCALAR_WIDTH-1:0] corner_value_7,
    input  logic signed [COORD_WIDTH-1:0]  origin_x,
    input  logic signed [COORD_WIDTH-1:0]  origin_y,
    input  logic signed [COORD_WIDTH-1:0]  origin_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [COORD_WIDTH-1:0]  vertex_x,
    output logic signed [COORD_WIDTH-1:0]  vertex_y,
    output logic signed [COORD_WIDTH-1:0]  vertex_z,
    output logic [3:0]                     cut_edge,
    output logic                           last_vertex
);

    typedef enum logic [2:0] {
        S_IDLE, S_CLASS, S_EDGE, S_SETUP, S_DIV, S_AXIS, S_EMIT
    } state_t;

    state_t state_reg;

    logic signed [SCALAR_WIDTH-1:0] iso_reg;
    logic [STEP_WIDTH-1:0] step_x_reg, step_y_reg, step_z_reg;

    logic signed [SCALAR_WIDTH-1:0] val_reg [8];
    logic signed [COORD_WIDTH-1:0]  org_reg [3];
    tri_row_t  row_reg;
    logic [3:0] k_reg;
    logic [1:0] axis_reg;
    edge_t      edge_reg;
    logic [2:0] ca_reg, cb_reg;
    logic [DIFF_WIDTH-1:0] den_reg;
    logic [PROD_WIDTH-1:0] prod_reg;
    logic [DIFF_WIDTH:0]   rem_reg;
    logic [QUOT_WIDTH-1:0] quot_reg;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg;
    logic signed [WIDE_WIDTH-1:0] pa_reg;
    logic       neg_reg;
    logic signed [COORD_WIDTH-1:0] res_reg [3];

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);

    // classification
    logic [7:0] corner_mask;
    always_comb
    begin
        for (int c = 0; c < 8; c++)
            corner_mask[c] = (val_reg[c] < iso_reg);
    end

    // edge setup
    logic signed [DIFF_WIDTH-1:0] va, vb, dnum, dden;
    logic [DIFF_WIDTH-1:0] setup_num, setup_den;
    always_comb
    begin
        va   = DIFF_WIDTH'(val_reg[ca_reg]);
        vb   = DIFF_WIDTH'(val_reg[cb_reg]);
        dnum = DIFF_WIDTH'(iso_reg) - va;
        dden = vb - va;
        if (dden < 0)
        begin
            dnum = -dnum;
            dden = -dden;
        end
        if (dden == 0 || dnum < 0 || dnum > dden)
        begin
            setup_num = '0;
            setup_den = DIFF_WIDTH'(1);
        end
        else
        begin
            setup_num = dnum;
            setup_den = dden;
        end
    end

    // per-axis corner offsets
    logic [STEP_WIDTH-1:0] step_sel;
    logic offa, offb;
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                step_sel = step_x_reg;
                offa = (ca_reg == 3'd1 || ca_reg == 3'd2 || ca_reg == 3'd5 || ca_reg == 3'd6);
                offb = (cb_reg == 3'd1 || cb_reg == 3'd2 || cb_reg == 3'd5 || cb_reg == 3'd6);
            end
            2'd1:
            begin
                step_sel = step_y_reg;
                offa = ca_reg[2];
                offb = cb_reg[2];
            end
            default:
            begin
                step_sel = step_z_reg;
                offa = (ca_reg == 3'd2 || ca_reg == 3'd3 || ca_reg == 3'd6 || ca_reg == 3'd7);
                offb = (cb_reg == 3'd2 || cb_reg == 3'd3 || cb_reg == 3'd6 || cb_reg == 3'd7);
            end
        endcase
    end

    logic [MAG_WIDTH-1:0] mag;
    assign mag = (offa != offb) ? step_sel : '0;

    // one restoring step: bring in the next product bit
    logic [DIFF_WIDTH:0] rem_sh;
    logic                rem_ge;
    assign rem_sh = {rem_reg[DIFF_WIDTH-1:0], prod_reg[PROD_WIDTH-1]};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    // finish: round half up, apply sign, saturate
    logic [QUOT_WIDTH-1:0] q_rnd;
    logic signed [WIDE_WIDTH+1:0] coord_full;
    logic signed [COORD_WIDTH-1:0] coord_sat;
    localparam logic signed [WIDE_WIDTH+1:0] CMAX = (WIDE_WIDTH+2)'(2**(COORD_WIDTH-1) - 1);
    localparam logic signed [WIDE_WIDTH+1:0] CMIN = -(WIDE_WIDTH+2)'(2**(COORD_WIDTH-1));
    always_comb
    begin
        q_rnd = quot_reg + QUOT_WIDTH'(({rem_reg, 1'b0} >= {2'b0, den_reg}) ? 1 : 0);
        if (neg_reg)
            coord_full = (WIDE_WIDTH+2)'(pa_reg) - (WIDE_WIDTH+2)'(signed'({1'b0, q_rnd}));
        else
            coord_full = (WIDE_WIDTH+2)'(pa_reg) + (WIDE_WIDTH+2)'(signed'({1'b0, q_rnd}));
        if (coord_full > CMAX)
            coord_sat = CMAX[COORD_WIDTH-1:0];
        else if (coord_full < CMIN)
            coord_sat = CMIN[COORD_WIDTH-1:0];
        else
            coord_sat = coord_full[COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            iso_reg     <= '0;
            step_x_reg  <= STEP_RESET;
            step_y_reg  <= STEP_RESET;
            step_z_reg  <= STEP_RESET;
            out_valid   <= 1'b0;
            k_reg       <= '0;
            axis_reg    <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        unique case (cfg_index)
                            REG_ISO:    iso_reg    <= cfg_data[SCALAR_WIDTH-1:0];
                            REG_STEP_X: step_x_reg <= cfg_data[STEP_WIDTH-1:0];
                            REG_STEP_Y: step_y_reg <= cfg_data[STEP_WIDTH-1:0];
                            REG_STEP_Z: step_z_reg <= cfg_data[STEP_WIDTH-1:0];
                        endcase
                    end
                    if (in_valid)
                    begin
                        val_reg[0] <= corner_value_0;
                        val_reg[1] <= corner_value_1;
                        val_reg[2] <= corner_value_2;
                        val_reg[3] <= corner_value_3;
                        val_reg[4] <= corner_value_4;
                        val_reg[5] <= corner_value_5;
                        val_reg[6] <= corner_value_6;
                        val_reg[7] <= corner_value_7;
                        org_reg[0] <= origin_x;
                        org_reg[1] <= origin_y;
                        org_reg[2] <= origin_z;
                        state_reg  <= S_CLASS;
                    end
                end
                S_CLASS:
                begin
                    row_reg <= tri_row(corner_mask);
                    k_reg   <= '0;
                    state_reg <= (tri_row(corner_mask).count == 4'd0) ? S_IDLE : S_EDGE;
                end
                S_EDGE:
                begin
                    edge_reg <= row_reg.edges[k_reg*4 +: 4];
                    ca_reg   <= edge_a(row_reg.edges[k_reg*4 +: 4]);
                    cb_reg   <= edge_b(row_reg.edges[k_reg*4 +: 4]);
                    axis_reg <= '0;
                    state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    den_reg  <= setup_den;
                    // span times num: one narrow multiply, registered
                    prod_reg <= PROD_WIDTH'(mag) * PROD_WIDTH'(setup_num);
                    pa_reg   <= WIDE_WIDTH'(org_reg[axis_reg])
                              + WIDE_WIDTH'(offa ? {1'b0, step_sel} : '0);
                    neg_reg  <= offa && !offb;
                    rem_reg  <= '0;
                    quot_reg <= '0;
                    cnt_reg  <= DIV_CNT_WIDTH'(PROD_WIDTH);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    prod_reg <= {prod_reg[PROD_WIDTH-2:0], 1'b0};
                    rem_reg  <= rem_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                    quot_reg <= {quot_reg[QUOT_WIDTH-2:0], rem_ge};
                    cnt_reg  <= cnt_reg - DIV_CNT_WIDTH'(1);
                    if (cnt_reg == DIV_CNT_WIDTH'(1))
                        state_reg <= S_AXIS;
                end
                S_AXIS:
                begin
                    res_reg[axis_reg] <= coord_sat;
                    if (axis_reg == 2'd2)
                    begin
                        out_valid <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_SETUP;
                    end
                end
                S_EMIT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= (k_reg + 4'd1 == row_reg.count) ? S_IDLE : S_EDGE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign vertex_x    = res_reg[0];
    assign vertex_y    = res_reg[1];
    assign vertex_z    = res_reg[2];
    assign cut_edge    = edge_reg;
    assign last_vertex = (k_reg + 4'd1 == row_reg.count);

endmodule

// ===== tb/marching_cubes_cell_polygonizer_tb.sv =====
// ----------------------------------------------------------------------------
// marching_cubes_cell_polygonizer_tb
// Drives voxels through the polygonizer under random input gaps and output
// stalls. A local model of the classification, triangle table and edge
// interpolation predicts each vertex beat, and each beat is checked in order.
// ----------------------------------------------------------------------------
module marching_cubes_cell_polygonizer_tb;
    import mccp_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 40;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic [3:0]                    edg;
        logic                          last;
    } vertex_t;

    typedef struct {
        logic signed [SCALAR_WIDTH-1:0] v [8];
        logic signed [COORD_WIDTH-1:0]  ox;
        logic signed [COORD_WIDTH-1:0]  oy;
        logic signed [COORD_WIDTH-1:0]  oz;
    } voxel_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [SCALAR_WIDTH-1:0] cv [8];
    logic signed [COORD_WIDTH-1:0] origin_x, origin_y, origin_z;
    logic out_valid;
    logic out_stall;
    logic signed [COORD_WIDTH-1:0] vertex_x, vertex_y, vertex_z;
    logic [3:0] cut_edge;
    logic last_vertex;

    marching_cubes_cell_polygonizer u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .corner_value_0(cv[0]), .corner_value_1(cv[1]),
        .corner_value_2(cv[2]), .corner_value_3(cv[3]),
        .corner_value_4(cv[4]), .corner_value_5(cv[5]),
        .corner_value_6(cv[6]), .corner_value_7(cv[7]),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .cut_edge(cut_edge), .last_vertex(last_vertex)
    );

    // edge lists per cube index, one hex digit per edge
    string tri_rows [256] = '{
"","083","019","183981","12a","08312a","92a029","2832a8a98",
"3b2","0b28b0","19023b","1b219b98b","3a1ba3","0a108a8ba","3903b9ba9","98aa8b",
"478","430734","019847","419471731","12a847","34730412a","92a902847","2a9297273794",
"8473b2","b47b24204","90184723b","47b94b9b2921","3a13ba784","1ba14b1047b4","47890b9bab03",
"47b4b99ba",
"954","954083","054150","854835315","12a954","30812a495","52a542402","2a5325354348",
"9543b2","0b208b495","05401523b","21525828b485","a3ba13954","4950818a18ba","54050b5bab03",
"54858aa8b",
"978579","930953573","078017157","153357","978957a12","a12950530573","802825857a52",
"2a5253357",
"7957893b2","95797292027b","23b018178157","b21b17715","958857a13a3b","5705097b010aba0",
"ba0b03a50807570","ba57b5",
"a65","0835a6","9015a6","1831985a6","165261","165126308","965906026","598582526328",
"23ba65","b08b20a65","01923b5a6","5a61929b298b","63b653513","08b0b50515b6","3b6036065059",
"65969bb98",
"5a6478","43047365a","1905a6847","a65197173794","612651478","125526304347","847905065026",
"739794329596269",
"3b2784a65","5a647242027b","01947823b5a6","9219b294b7b45a6","8473b53515b6",
"51b5b610b7b404b","059065036b63847","65969b4797b9",
"a4964a","4a649a083","a01a06640","83181686461a","149124264","308129249264","024426",
"832824426",
"a49a64b23","08228b49a4a6","3b201606461a","64161a48121b8b1","964936913b63",
"8b1810b61914641","3b6360064","648b68",
"7a678a89a","0730a709a67a","a671a7178180","a67a71173","126168189867","269291679093739",
"780706602","732672",
"23ba68a89867","20727b09767a9a7","1801781a767a23b","b21b17a61671","896867916b63136",
"091b67","7807063b0b60","7b6",
"76b","308b76","019b76","819831b76","a126b7","12a3086b7","2902a96b7","6b72a3a83a98",
"723627","708760620","276237019","162186198876","a76a17137","a7617a187108","03707a0a96a7",
"76a7a88a9",
"684b86","36b306046","86b846901","946963931b36","6846b82a1","12a30b06b046","4b846b0292a9",
"a93a32943b36463",
"823842462","042462","190234246438","194142246","8138618466a1","a10a06604",
"4634386a3039a93","a946a4",
"49576b","083495b76","50154076b","b76834354315","954a1276b","6b712a083495","76b54a42a402",
"348354325a52b76",
"723762549","954086062687","362376150540","628687218485158","954a16176137",
"16a176107870954","40a4a503a6a737a","76a7a854a48a",
"6956b9b89","36b063056095","0b805b01556b","6b3635531","12a95b9b8b56","0b306b09656912a",
"b85b56805a52025","6b36352a3a53",
"589528562382","956960062","158180568382628","156216","13616a386569896","a10a06950560",
"03856a","a56",
"b5a75b","b5ab75830","5b75ab190","a75ab7981831","b12b17751","08312717572b","9759279022b7",
"75272b592328982",
"25a235375","820852875a25","9015a35373a2","982921872a25752","135375","087071175",
"903935537","987597",
"5845a8ab8","5045b05abb30","01984a8aba45","ab4a45b34941314","2512852b8458",
"04b0b345b2b151b","0250592b5458b85","9452b3",
"25a352345384","5a2524420","3a235a385458019","5a2524192942","845853351","045105",
"845853905035","945",
"4b749b9ab","0834979b79ab","1ab1b414074b","3143481a474bab4","4b79b492b912",
"9749b791b2b1083","b74b42240","b74b42834324",
"29a279237749","9a7974a27870207","37a3a274a1a040a","1a2874","491417713","491417081871",
"403743","487",
"9a8ab8","30939bb9a","01a0a88ab","31ab3a","12b1b99b8","30939b1292b9","02b80b","32b",
"23828aa89","9a2092","23828a0181a8","1a2","138918","091","038",""
    };

    int unsigned corner_lo [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
    int unsigned corner_hi [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};
    bit dx [8] = '{0, 1, 1, 0, 0, 1, 1, 0};
    bit dy [8] = '{0, 0, 0, 0, 1, 1, 1, 1};
    bit dz [8] = '{0, 0, 1, 1, 0, 0, 1, 1};

    // local copy of the registers
    logic signed [SCALAR_WIDTH-1:0] iso_q;
    logic [STEP_WIDTH-1:0] step_x_q, step_y_q, step_z_q;

    vertex_t vertex_q [$];
    int unsigned fail_cnt;
    int unsigned voxels_sent;
    int unsigned vertices_seen;
    int unsigned idle_cnt;
    int unsigned burst_left;
    int unsigned stall_mode;
    int unsigned stall_hold;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- model
    function automatic longint sat_coord(input longint v);
        longint hi;
        hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint lerp(input longint pa, input longint pb,
                                    input longint num, input longint den);
        longint span, mag, prod, q, r;
        span = pb - pa;
        mag  = (span < 0) ? -span : span;
        prod = mag * num;
        q    = prod / den;
        r    = prod % den;
        if (2 * r >= den) q = q + 1;
        return (span < 0) ? pa - q : pa + q;
    endfunction

    task automatic polygonize_voxel(input voxel_t vx);
        longint iso, val [8], px [8], py [8], pz [8], num, den;
        int unsigned idx, n, e, a, b;
        byte ch;
        string row;
        vertex_t vt;
        iso = longint'(iso_q);
        idx = 0;
        for (int c = 0; c < 8; c++)
        begin
            val[c] = longint'(vx.v[c]);
            if (val[c] < iso) idx |= (1 << c);
            px[c] = longint'(vx.ox) + (dx[c] ? longint'(step_x_q) : 0);
            py[c] = longint'(vx.oy) + (dy[c] ? longint'(step_y_q) : 0);
            pz[c] = longint'(vx.oz) + (dz[c] ? longint'(step_z_q) : 0);
        end
        row = tri_rows[idx];
        n = row.len();
        for (int k = 0; k < n; k++)
        begin
            ch = row[k];
            e = (ch >= "a") ? ch - "a" + 10 : ch - "0";
            a = corner_lo[e];
            b = corner_hi[e];
            num = iso - val[a];
            den = val[b] - val[a];
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            if (den == 0 || num < 0 || num > den)
            begin
                num = 0;
                den = 1;
            end
            vt.x    = COORD_WIDTH'(sat_coord(lerp(px[a], px[b], num, den)));
            vt.y    = COORD_WIDTH'(sat_coord(lerp(py[a], py[b], num, den)));
            vt.z    = COORD_WIDTH'(sat_coord(lerp(pz[a], pz[b], num, den)));
            vt.edg  = 4'(e);
            vt.last = (k == n - 1);
            vertex_q.push_back(vt);
        end
    endtask

    // ---------------------------------------------------------- output side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            stall_hold <= 0;
            idle_cnt   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                vertex_t ex;
                vertices_seen++;
                if (vertex_q.size() == 0)
                begin
                    $error("vertex beat with none expected");
                    fail_cnt++;
                end
                else
                begin
                    ex = vertex_q.pop_front();
                    if (vertex_x !== ex.x)
                    begin
                        $error("vertex_x: expected %0d, got %0d", ex.x, vertex_x);
                        fail_cnt++;
                    end
                    if (vertex_y !== ex.y)
                    begin
                        $error("vertex_y: expected %0d, got %0d", ex.y, vertex_y);
                        fail_cnt++;
                    end
                    if (vertex_z !== ex.z)
                    begin
                        $error("vertex_z: expected %0d, got %0d", ex.z, vertex_z);
                        fail_cnt++;
                    end
                    if (cut_edge !== ex.edg)
                    begin
                        $error("cut_edge: expected %0d, got %0d", ex.edg, cut_edge);
                        fail_cnt++;
                    end
                    if (last_vertex !== ex.last)
                    begin
                        $error("last_vertex: expected %0d, got %0d", ex.last, last_vertex);
                        fail_cnt++;
                    end
                end
            end
            // stall pattern: none, light, heavy, near-solid, held per stretch
            if (stall_hold == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_hold <= $urandom_range(64, 600);
            end
            else
                stall_hold <= stall_hold - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ($urandom_range(0, 19) != 0);
            endcase
            // watchdog
            if ((out_valid && !out_stall) || (in_valid && !in_stall)
                || (cfg_valid && cfg_ready))
                idle_cnt <= 0;
            else if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("marching_cubes_cell_polygonizer_tb failed");
                $finish;
            end
            else
                idle_cnt <= idle_cnt + 1;
        end
    end

    // ------------------------------------------------------------ input side
    task automatic send_voxel(input voxel_t vx);
        int unsigned gap;
        in_valid <= 1'b1;
        for (int c = 0; c < 8; c++) cv[c] <= vx.v[c];
        origin_x <= vx.ox;
        origin_y <= vx.oy;
        origin_z <= vx.oz;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        polygonize_voxel(vx);
        voxels_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 400)
                                              : $urandom_range(0, 20);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // wait until every expected vertex has gone and the block has settled
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (vertex_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ISO:    iso_q    = data[SCALAR_WIDTH-1:0];
            REG_STEP_X: step_x_q = data[STEP_WIDTH-1:0];
            REG_STEP_Y: step_y_q = data[STEP_WIDTH-1:0];
            default:    step_z_q = data[STEP_WIDTH-1:0];
        endcase
    endtask

    task automatic set_config(input int iso, input int sx, input int sy, input int sz);
        // upper data bits carry junk that the block must drop
        write_reg(REG_ISO, {16'($urandom_range(0, 65535)), 16'(iso)});
        write_reg(REG_STEP_X, {9'($urandom), 23'(sx)});
        write_reg(REG_STEP_Y, {9'($urandom), 23'(sy)});
        write_reg(REG_STEP_Z, {9'($urandom), 23'(sz)});
    endtask

    function automatic voxel_t flat_voxel(input int val, input int ox, input int oy,
                                          input int oz);
        voxel_t vx;
        for (int c = 0; c < 8; c++) vx.v[c] = SCALAR_WIDTH'(val);
        vx.ox = COORD_WIDTH'(ox);
        vx.oy = COORD_WIDTH'(oy);
        vx.oz = COORD_WIDTH'(oz);
        return vx;
    endfunction

    // random voxel: mostly a chosen corner pattern straddling the iso level
    function automatic voxel_t random_voxel;
        voxel_t vx;
        int unsigned pat, span, sel;
        longint iso, t;
        iso = longint'(iso_q);
        pat = $urandom_range(0, 255);
        sel = $urandom_range(0, 2);
        span = (sel == 0) ? 16 : (sel == 1) ? 1024 : 65535;
        for (int c = 0; c < 8; c++)
        begin
            if ($urandom_range(0, 9) == 0)
                t = $signed(16'($urandom));
            else if (pat[c])
                t = iso - 1 - $urandom_range(0, span);
            else
                t = iso + $urandom_range(0, span);
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
            vx.v[c] = SCALAR_WIDTH'(t);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            vx.ox = COORD_WIDTH'($urandom);
            vx.oy = COORD_WIDTH'($urandom);
            vx.oz = COORD_WIDTH'($urandom);
        end
        else
        begin
            vx.ox = COORD_WIDTH'($signed(17'($urandom)));
            vx.oy = COORD_WIDTH'($signed(17'($urandom)));
            vx.oz = COORD_WIDTH'($signed(17'($urandom)));
        end
        return vx;
    endfunction

    // -------------------------------------------------------------- tests
    task automatic test_reset_config;
        voxel_t vx;
        // corner 0 alone below iso, midway on every edge of corner 0, twice; then only corners 0 and 6 not below iso
        vx = flat_voxel(256, 0, 0, 0);
        vx.v[0] = -256;
        send_voxel(vx);
        vx = flat_voxel(1, 4096, -4096, 12345);
        vx.v[0] = -1;
        send_voxel(vx);
        vx = flat_voxel(-3, 100, 200, 300);
        vx.v[6] = 0;
        vx.v[0] = 5;
        send_voxel(vx);
    endtask

    task automatic test_empty_voxels;
        send_voxel(flat_voxel(32767, 0, 0, 0));
        send_voxel(flat_voxel(-32768, 1, 2, 3));
        // value equal to iso counts as not below
        send_voxel(flat_voxel(0, -1, -1, -1));
    endtask

    task automatic test_extremes;
        voxel_t vx;
        set_config(-32768, 8388607, 8388607, 8388607);
        // nothing can lie below the lowest iso level
        send_voxel(flat_voxel(-32768, 0, 0, 0));
        set_config(32767, 8388607, 8388607, 8388607);
        vx = flat_voxel(-32768, 8388607, 8388607, 8388607);
        vx.v[6] = 32767;
        send_voxel(vx);
        vx = flat_voxel(32767, -8388608, -8388608, -8388608);
        vx.v[0] = -32768;
        send_voxel(vx);
        // corner pattern with the full fifteen vertices, saturating high
        vx = flat_voxel(32767, 8000000, 8000000, 8000000);
        for (int c = 0; c < 8; c++)
            if (c == 0 || c == 1 || c == 2 || c == 4 || c == 6) vx.v[c] = -32768;
        send_voxel(vx);
        set_config(0, 0, 0, 0);
        vx = flat_voxel(100, -5, 7, 9);
        vx.v[3] = -100;
        vx.v[5] = -100;
        send_voxel(vx);
        set_config(0, 4096, 4096, 4096);
    endtask

    task automatic test_random_phases;
        int sets [7][4] = '{
            '{0, 4096, 4096, 4096},
            '{-32768, 1, 8388607, 2},
            '{32767, 8388607, 0, 4096},
            '{$signed(16'($urandom)), $urandom_range(0, 8388607),
              $urandom_range(0, 8388607), $urandom_range(0, 8388607)},
            '{$signed(16'($urandom)), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535)},
            '{-1, 2048, 128, 8388607},
            '{128, 4096, 4096, 4096}
        };
        for (int p = 0; p < 7; p++)
        begin
            set_config(sets[p][0], sets[p][1], sets[p][2], sets[p][3]);
            for (int i = 0; i < 45; i++)
            begin
                send_voxel(random_voxel());
                // hold the sender back until everything has come out
                if (p == 3 && i == 20) drain();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        for (int c = 0; c < 8; c++) cv[c] = '0;
        origin_x = '0;
        origin_y = '0;
        origin_z = '0;
        iso_q    = '0;
        step_x_q = STEP_RESET;
        step_y_q = STEP_RESET;
        step_z_q = STEP_RESET;
        fail_cnt = 0;
        voxels_sent = 0;
        vertices_seen = 0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_empty_voxels();
        test_extremes();
        test_random_phases();
        drain();

        if (vertex_q.size() != 0)
        begin
            $error("%0d expected vertices never arrived", vertex_q.size());
            fail_cnt++;
        end
        $display("%0d voxels in, %0d vertex beats checked, across 11 register settings",
                 voxels_sent, vertices_seen);
        if (fail_cnt == 0)
            $display("marching_cubes_cell_polygonizer_tb passed");
        else
            $display("marching_cubes_cell_polygonizer_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mccp_pkg.sv
rtl/core/marching_cubes_cell_polygonizer.sv
tb/marching_cubes_cell_polygonizer_tb.sv
